// ===== hdl/spt_pkg.sv =====
`timescale 1ns / 1ps

package spt_pkg;

    // trig table default and format
    localparam int SPT_SINE_TABLE_BITS = 10;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam int TAYLOR_TERMS = 12;

    // (2n)(2n+1) for the sine series terms
    localparam logic [15:0] TAYLOR_DEN [1:TAYLOR_TERMS] = '{
        16'd6, 16'd20, 16'd42, 16'd72, 16'd110, 16'd156,
        16'd210, 16'd272, 16'd342, 16'd420, 16'd506, 16'd600
    };

    // configuration port
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_POINT_STRIDE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SCANS = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_POINTS = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DT = 4'd3;

    localparam logic [7:0] RST_POINT_STRIDE = 8'd1;
    localparam logic [15:0] RST_MIN_SCANS = 16'd1;
    localparam logic [15:0] RST_MIN_POINTS = 16'd3;
    localparam logic [31:0] RST_MAX_DT = 32'd500000;

    localparam logic signed [16:0] TRIG_ONE = 17'sd32768;
    localparam logic [15:0] COUNT_MAX = 16'hffff;

    typedef enum logic [1:0] {
        OP_CENTER = 2'd0,
        OP_HEADER = 2'd1,
        OP_POINT = 2'd2,
        OP_END = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_FRAME = 2'd1,
        KIND_VERDICT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        VERDICT_AVAILABLE = 2'd0,
        VERDICT_NO_CENTER = 2'd1,
        VERDICT_FEW_SCANS = 2'd2,
        VERDICT_FEW_POINTS = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic signed [31:0] scan_id;
        logic [31:0] stamp_us;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0] yaw;
        logic data_ok;
    } in_item_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_scan_id;
        logic [1:0] verdict_code;
        logic available;
        logic [15:0] kept_points;
        logic [15:0] kept_scans;
    } out_item_t;

    // one entry of the quarter-wave sine table, Q1.15, built at elaboration
    function automatic logic [15:0] quarter_sine(input int unsigned k,
                                                 input int unsigned qbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] val;
        int n;
        x = (PI_HALF_Q30 * 64'(k) + ((64'd1 << qbits) >> 1)) >> qbits;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (n = 1; n <= TAYLOR_TERMS; n++)
        begin
            term = ((term * x2) >> 30) / 64'(TAYLOR_DEN[n]);
            if (n % 2 == 1)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        val = (sum + 64'd16384) >> 15;
        if (val > 64'd32768)
        begin
            val = 64'd32768;
        end
        return val[15:0];
    endfunction

endpackage

// ===== hdl/spt_trig.sv =====
`timescale 1ns / 1ps

module spt_trig
    import spt_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SPT_SINE_TABLE_BITS
)
(
    input  logic [15:0]        angle,
    output logic signed [16:0] sin_q,
    output logic signed [16:0] cos_q
);

    localparam int B = SINE_TABLE_BITS;
    localparam int QBITS = B - 2;
    localparam int QLEN = 1 << QBITS;

    logic [15:0] qtab [QLEN+1];
    logic [16:0] angle_rnd;
    logic [B-1:0] idx [2];
    logic signed [16:0] val [2];

    // quarter-wave table as constants
    for (genvar k = 0; k <= QLEN; k++)
    begin : g_tab
        localparam logic [15:0] ENTRY = quarter_sine(k, QBITS);
        assign qtab[k] = ENTRY;
    end

    // round the binary angle to the table resolution
    assign angle_rnd = {1'b0, angle} + 17'(1 << (15 - B));
    assign idx[0] = angle_rnd[15:16-B];
    assign idx[1] = idx[0] + B'(QLEN);

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic [1:0] quad;
        logic [B-2:0] r;
        logic [B-2:0] rc;
        logic signed [16:0] mag;
        always_comb
        begin
            quad = idx[l][B-1:B-2];
            r = {1'b0, idx[l][B-3:0]};
            rc = (B-1)'(QLEN) - r;
            mag = quad[0] ? $signed({1'b0, qtab[rc]}) : $signed({1'b0, qtab[r]});
            val[l] = quad[1] ? -mag : mag;
        end
    end

    assign sin_q = val[0];
    assign cos_q = val[1];

endmodule

// ===== hdl/spt_rotate.sv =====
`timescale 1ns / 1ps

module spt_rotate
    import spt_pkg::*;
(
    input  logic signed [16:0] c,
    input  logic signed [16:0] s,
    input  logic signed [32:0] u,
    input  logic signed [32:0] v,
    input  logic signed [31:0] tx,
    input  logic signed [31:0] ty,
    output logic signed [31:0] a,
    output logic signed [31:0] b,
    output logic               ovf
);

    logic signed [49:0] p_cu;
    logic signed [49:0] p_sv;
    logic signed [49:0] p_su;
    logic signed [49:0] p_cv;
    logic signed [51:0] acc_a;
    logic signed [51:0] acc_b;
    logic signed [51:0] sh_a;
    logic signed [51:0] sh_b;
    logic ovf_a;
    logic ovf_b;

    // a = c*u - s*v + tx, b = s*u + c*v + ty, all in Q1.15 scale
    always_comb
    begin
        p_cu = c * u;
        p_sv = s * v;
        p_su = s * u;
        p_cv = c * v;
        acc_a = 52'(p_cu) - 52'(p_sv) + (52'(tx) <<< 15) + 52'sd16384;
        acc_b = 52'(p_su) + 52'(p_cv) + (52'(ty) <<< 15) + 52'sd16384;
        // round half toward plus infinity
        sh_a = acc_a >>> 15;
        sh_b = acc_b >>> 15;
        ovf_a = (sh_a[51:31] != '0) && (sh_a[51:31] != '1);
        ovf_b = (sh_b[51:31] != '0) && (sh_b[51:31] != '1);
    end

    assign a = sh_a[31:0];
    assign b = sh_b[31:0];
    assign ovf = ovf_a || ovf_b;

endmodule

// ===== hdl/submap_point_transform.sv =====
`timescale 1ns / 1ps

// submap point transform: builds one 2d point-cloud submap from an item stream
// input channel (in_valid / in_ready / in_data): center pose, frame header,
//   point or end-of-submap items, one transfer per cycle when not stalled
// output channel (out_valid / out_ready / out_data): transformed points,
//   accepted frame ids and the end-of-submap verdict with its counts
// config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready,
//   written between submaps while no item is in flight
// pipeline: input register, then one pass of rotate-and-add plus table
//   lookup, then the result register; all submap state updates in that pass
// result path: an item is held in the input register and its result in the result
//   register, which drives out_data and transfers when out_ready is high
// throughput: 1 item per cycle unless the receiver stalls; the single pass through
//   the shared rotate unit (four 17x33 multipliers) sets the cycle
// items that give no result (center, rejected header, skipped point) just
//   leave the pipeline without touching the output
// receiver stall: the result register holds; the input register still drains
//   into the result register if that one is empty, otherwise in_ready drops
// reset: clears both pipeline valids, submap state and config to defaults
//   (stride 1, one scan, three points, 500000 us); no clearing pass needed
module submap_point_transform
    import spt_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SPT_SINE_TABLE_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    // config registers
    logic [7:0]  stride_reg;
    logic [15:0] min_scans_reg;
    logic [15:0] min_points_reg;
    logic [31:0] max_dt_reg;

    // pipeline registers
    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg;

    // submap state
    logic signed [31:0] center_x_reg, center_x_next;
    logic signed [31:0] center_y_reg, center_y_next;
    logic signed [16:0] center_cos_reg, center_cos_next;
    logic signed [16:0] center_sin_reg, center_sin_next;
    logic [15:0]        center_yaw_reg, center_yaw_next;
    logic [31:0]        center_stamp_reg, center_stamp_next;
    logic               center_present_reg, center_present_next;
    logic signed [31:0] rel_tx_reg, rel_tx_next;
    logic signed [31:0] rel_ty_reg, rel_ty_next;
    logic signed [16:0] rel_cos_reg, rel_cos_next;
    logic signed [16:0] rel_sin_reg, rel_sin_next;
    logic               rel_ovf_reg, rel_ovf_next;
    logic               frame_acc_reg, frame_acc_next;
    logic [7:0]         phase_reg, phase_next;
    logic [15:0]        points_reg, points_next;
    logic [15:0]        scans_reg, scans_next;

    // datapath
    logic               proc_fire;
    opcode_t            op;
    logic [15:0]        trig_angle;
    logic signed [16:0] trig_sin;
    logic signed [16:0] trig_cos;
    logic [31:0]        stamp_diff;
    logic               hdr_ok;
    logic signed [16:0] rot_c;
    logic signed [16:0] rot_s;
    logic signed [32:0] rot_u;
    logic signed [32:0] rot_v;
    logic signed [31:0] rot_tx;
    logic signed [31:0] rot_ty;
    logic signed [31:0] rot_a;
    logic signed [31:0] rot_b;
    logic               rot_ovf;
    logic [7:0]         stride_eff;
    logic [8:0]         phase_inc;
    logic               take;
    verdict_t           verdict;
    logic               res_valid;
    out_item_t          res_data;

    // the input register moves on whenever the result register can take it
    assign proc_fire = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || proc_fire;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    assign op = opcode_t'(in_data_reg.opcode);

    // center items take the sine of their own heading, headers of the relative one
    assign trig_angle = (op == OP_CENTER) ? in_data_reg.yaw
                                          : in_data_reg.yaw - center_yaw_reg;

    spt_trig #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_trig (
        .angle(trig_angle),
        .sin_q(trig_sin),
        .cos_q(trig_cos)
    );

    // header check against the center stamp
    assign stamp_diff = (in_data_reg.stamp_us > center_stamp_reg)
                        ? in_data_reg.stamp_us - center_stamp_reg
                        : center_stamp_reg - in_data_reg.stamp_us;
    assign hdr_ok = center_present_reg && in_data_reg.data_ok && (stamp_diff <= max_dt_reg);

    // shared rotate unit: header gives R(-center yaw) * (frame - center),
    // point gives R(rel yaw) * p + rel translation
    always_comb
    begin
        if (op == OP_HEADER)
        begin
            rot_c = center_cos_reg;
            rot_s = -center_sin_reg;
            rot_u = 33'(in_data_reg.pos_x) - 33'(center_x_reg);
            rot_v = 33'(in_data_reg.pos_y) - 33'(center_y_reg);
            rot_tx = '0;
            rot_ty = '0;
        end
        else
        begin
            rot_c = rel_cos_reg;
            rot_s = rel_sin_reg;
            rot_u = 33'(in_data_reg.pos_x);
            rot_v = 33'(in_data_reg.pos_y);
            rot_tx = rel_tx_reg;
            rot_ty = rel_ty_reg;
        end
    end

    spt_rotate u_rotate (
        .c(rot_c),
        .s(rot_s),
        .u(rot_u),
        .v(rot_v),
        .tx(rot_tx),
        .ty(rot_ty),
        .a(rot_a),
        .b(rot_b),
        .ovf(rot_ovf)
    );

    // stride handling, a zero stride acts as one
    assign stride_eff = (stride_reg == '0) ? 8'd1 : stride_reg;
    assign phase_inc = {1'b0, phase_reg} + 9'd1;
    assign take = (phase_reg == '0);

    always_comb
    begin
        if (!center_present_reg)
        begin
            verdict = VERDICT_NO_CENTER;
        end
        else if (scans_reg < min_scans_reg)
        begin
            verdict = VERDICT_FEW_SCANS;
        end
        else if (points_reg < min_points_reg)
        begin
            verdict = VERDICT_FEW_POINTS;
        end
        else
        begin
            verdict = VERDICT_AVAILABLE;
        end
    end

    // submap state update and result for the item in the input register
    always_comb
    begin
        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        center_cos_next = center_cos_reg;
        center_sin_next = center_sin_reg;
        center_yaw_next = center_yaw_reg;
        center_stamp_next = center_stamp_reg;
        center_present_next = center_present_reg;
        rel_tx_next = rel_tx_reg;
        rel_ty_next = rel_ty_reg;
        rel_cos_next = rel_cos_reg;
        rel_sin_next = rel_sin_reg;
        rel_ovf_next = rel_ovf_reg;
        frame_acc_next = frame_acc_reg;
        phase_next = phase_reg;
        points_next = points_reg;
        scans_next = scans_reg;
        res_valid = 1'b0;
        res_data = '0;
        if (proc_fire)
        begin
            case (op)
                OP_CENTER:
                begin
                    center_present_next = in_data_reg.data_ok;
                    if (in_data_reg.data_ok)
                    begin
                        center_x_next = in_data_reg.pos_x;
                        center_y_next = in_data_reg.pos_y;
                        center_yaw_next = in_data_reg.yaw;
                        center_stamp_next = in_data_reg.stamp_us;
                        center_sin_next = trig_sin;
                        center_cos_next = trig_cos;
                    end
                end
                OP_HEADER:
                begin
                    frame_acc_next = hdr_ok;
                    if (hdr_ok)
                    begin
                        rel_tx_next = rot_a;
                        rel_ty_next = rot_b;
                        rel_ovf_next = rot_ovf;
                        rel_sin_next = trig_sin;
                        rel_cos_next = trig_cos;
                        phase_next = '0;
                        scans_next = (scans_reg == COUNT_MAX) ? scans_reg : scans_reg + 16'd1;
                        res_valid = 1'b1;
                        res_data.result_kind = KIND_FRAME;
                        res_data.out_scan_id = in_data_reg.scan_id;
                    end
                end
                OP_POINT:
                begin
                    if (frame_acc_reg)
                    begin
                        phase_next = (phase_inc >= {1'b0, stride_eff}) ? 8'd0 : phase_inc[7:0];
                        if (take && in_data_reg.data_ok && !rel_ovf_reg && !rot_ovf)
                        begin
                            points_next = (points_reg == COUNT_MAX) ? points_reg
                                                                    : points_reg + 16'd1;
                            res_valid = 1'b1;
                            res_data.result_kind = KIND_POINT;
                            res_data.out_x = rot_a;
                            res_data.out_y = rot_b;
                        end
                    end
                end
                OP_END:
                begin
                    res_valid = 1'b1;
                    res_data.result_kind = KIND_VERDICT;
                    res_data.verdict_code = verdict;
                    res_data.available = (verdict == VERDICT_AVAILABLE);
                    res_data.kept_points = points_reg;
                    res_data.kept_scans = scans_reg;
                    points_next = '0;
                    scans_next = '0;
                    frame_acc_next = 1'b0;
                    phase_next = '0;
                    center_present_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (proc_fire)
        begin
            out_valid_next = res_valid;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_cos_reg <= TRIG_ONE;
            center_sin_reg <= '0;
            center_yaw_reg <= '0;
            center_stamp_reg <= '0;
            center_present_reg <= 1'b0;
            rel_tx_reg <= '0;
            rel_ty_reg <= '0;
            rel_cos_reg <= TRIG_ONE;
            rel_sin_reg <= '0;
            rel_ovf_reg <= 1'b0;
            frame_acc_reg <= 1'b0;
            phase_reg <= '0;
            points_reg <= '0;
            scans_reg <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc_fire)
            begin
                in_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
            center_x_reg <= center_x_next;
            center_y_reg <= center_y_next;
            center_cos_reg <= center_cos_next;
            center_sin_reg <= center_sin_next;
            center_yaw_reg <= center_yaw_next;
            center_stamp_reg <= center_stamp_next;
            center_present_reg <= center_present_next;
            rel_tx_reg <= rel_tx_next;
            rel_ty_reg <= rel_ty_next;
            rel_cos_reg <= rel_cos_next;
            rel_sin_reg <= rel_sin_next;
            rel_ovf_reg <= rel_ovf_next;
            frame_acc_reg <= frame_acc_next;
            phase_reg <= phase_next;
            points_reg <= points_next;
            scans_reg <= scans_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (proc_fire && res_valid)
        begin
            out_data_reg <= res_data;
        end
    end

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= RST_POINT_STRIDE;
            min_scans_reg <= RST_MIN_SCANS;
            min_points_reg <= RST_MIN_POINTS;
            max_dt_reg <= RST_MAX_DT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_POINT_STRIDE: stride_reg <= cfg_data[7:0];
                CFG_MIN_SCANS:    min_scans_reg <= cfg_data[15:0];
                CFG_MIN_POINTS:   min_points_reg <= cfg_data[15:0];
                CFG_MAX_DT:       max_dt_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // end of submap leaves a cleared submap behind
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && (op == OP_END) |=>
            !center_present_reg && !frame_acc_reg && (points_reg == '0) && (scans_reg == '0))
        else $error("end item did not clear the submap state");

    // the available flag agrees with the verdict code
    a_verdict_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.result_kind == KIND_VERDICT) |->
            (out_data_reg.available == (out_data_reg.verdict_code == VERDICT_AVAILABLE)))
        else $error("available flag disagrees with verdict code");

    // an empty input stage never blocks the sender
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ready)
        else $error("input stalled while the input register is empty");

    // points come out only inside an accepted frame with a usable translation
    a_point_gate: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && res_valid && (op == OP_POINT) |->
            frame_acc_reg && !rel_ovf_reg && in_data_reg.data_ok)
        else $error("point emitted outside an accepted frame");

    // an accepted header always leaves a nonzero scan count
    a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && res_valid && (op == OP_HEADER) |=> (scans_reg != '0) && frame_acc_reg)
        else $error("accepted header not counted");

endmodule

// ===== tb/spt_checker.sv =====
`timescale 1ns / 1ps

module spt_checker
    import spt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  in_item_t               in_data,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  out_item_t              out_data,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data,
    output int                     mismatches,
    output int                     results_due,
    output int                     points_seen,
    output int                     frames_seen,
    output int                     verdicts_seen,
    output int                     available_seen
);

    localparam int TRIG_BITS = 10;
    localparam int QUARTER = 1 << (TRIG_BITS - 2);
    localparam int TURN = 1 << TRIG_BITS;
    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;
    localparam int PRINT_LIMIT = 30;

    longint sine_quarter [0:QUARTER];

    // register copies
    logic [7:0]  stride_cfg;
    logic [15:0] min_scans_cfg;
    logic [15:0] min_points_cfg;
    logic [31:0] max_dt_cfg;

    // submap state
    longint      ctr_x, ctr_y, ctr_cos, ctr_sin;
    logic [15:0] ctr_yaw;
    logic [31:0] ctr_stamp;
    bit          ctr_present;
    longint      rel_x, rel_y, rel_cos, rel_sin;
    bit          rel_overflow, in_frame;
    int          stride_pos;
    logic [15:0] kept_pts, kept_frames;

    out_item_t   transfers_due [$];
    bit          step_emits;
    out_item_t   step_result;

    // quarter-wave sine, Q1.15, from a truncated Taylor series in Q30
    initial
    begin
        longint unsigned x, x2, term, acc, v;
        for (int k = 0; k <= QUARTER; k++)
        begin
            x = (PI_HALF_Q30 * k + QUARTER / 2) / QUARTER;
            x2 = (x * x) >> 30;
            term = x;
            acc = x;
            for (int n = 1; n <= 12; n++)
            begin
                term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    acc = acc - term;
                else
                    acc = acc + term;
            end
            v = (acc + 64'd16384) >> 15;
            if (v > 64'd32768)
                v = 64'd32768;
            sine_quarter[k] = v;
        end
    end

    function automatic longint sine_at(int idx);
        int i, r;
        i = idx & (TURN - 1);
        r = i & (QUARTER - 1);
        case ((i >> (TRIG_BITS - 2)) & 3)
            0: return sine_quarter[r];
            1: return sine_quarter[QUARTER - r];
            2: return -sine_quarter[r];
            default: return -sine_quarter[QUARTER - r];
        endcase
    endfunction

    function automatic int heading_index(logic [15:0] a);
        return ((int'(a) + (1 << (15 - TRIG_BITS))) >> (16 - TRIG_BITS)) & (TURN - 1);
    endfunction

    // floor((v + 2^14) / 2^15)
    function automatic longint round15(longint v);
        return (v + 64'sd16384) >>> 15;
    endfunction

    function automatic bit fits32(longint v);
        return v >= I32_MIN && v <= I32_MAX;
    endfunction

    function automatic logic [15:0] bump(logic [15:0] c);
        return (c == COUNT_MAX) ? c : c + 16'd1;
    endfunction

    task automatic restore_defaults();
        stride_cfg = RST_POINT_STRIDE;
        min_scans_cfg = RST_MIN_SCANS;
        min_points_cfg = RST_MIN_POINTS;
        max_dt_cfg = RST_MAX_DT;
        ctr_x = 0;
        ctr_y = 0;
        ctr_cos = 32768;
        ctr_sin = 0;
        ctr_yaw = '0;
        ctr_stamp = '0;
        ctr_present = 0;
        rel_x = 0;
        rel_y = 0;
        rel_cos = 32768;
        rel_sin = 0;
        rel_overflow = 0;
        in_frame = 0;
        stride_pos = 0;
        kept_pts = '0;
        kept_frames = '0;
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        case (idx)
            CFG_POINT_STRIDE: stride_cfg = data[7:0];
            CFG_MIN_SCANS:    min_scans_cfg = data[15:0];
            CFG_MIN_POINTS:   min_points_cfg = data[15:0];
            CFG_MAX_DT:       max_dt_cfg = data;
            default:          ;
        endcase
    endtask

    task automatic advance_submap(input in_item_t item, output bit emits,
                                  output out_item_t res);
        logic [31:0] gap;
        logic [15:0] rel_yaw;
        longint      px, py, dx, dy, ox, oy;
        int          stride;
        bit          take;
        verdict_t    code;
        emits = 0;
        res = '0;
        px = $signed(item.pos_x);
        py = $signed(item.pos_y);
        case (item.opcode)
            OP_CENTER:
            begin
                ctr_present = item.data_ok;
                if (item.data_ok)
                begin
                    ctr_x = px;
                    ctr_y = py;
                    ctr_yaw = item.yaw;
                    ctr_stamp = item.stamp_us;
                    ctr_sin = sine_at(heading_index(item.yaw));
                    ctr_cos = sine_at(heading_index(item.yaw) + QUARTER);
                end
            end
            OP_HEADER:
            begin
                gap = (item.stamp_us > ctr_stamp) ? item.stamp_us - ctr_stamp
                                                   : ctr_stamp - item.stamp_us;
                in_frame = ctr_present && item.data_ok && gap <= max_dt_cfg;
                if (in_frame)
                begin
                    // frame offset expressed in the center frame
                    dx = px - ctr_x;
                    dy = py - ctr_y;
                    rel_x = round15(ctr_cos * dx + ctr_sin * dy);
                    rel_y = round15(ctr_cos * dy - ctr_sin * dx);
                    rel_overflow = !fits32(rel_x) || !fits32(rel_y);
                    rel_yaw = item.yaw - ctr_yaw;
                    rel_sin = sine_at(heading_index(rel_yaw));
                    rel_cos = sine_at(heading_index(rel_yaw) + QUARTER);
                    stride_pos = 0;
                    kept_frames = bump(kept_frames);
                    emits = 1;
                    res.result_kind = KIND_FRAME;
                    res.out_scan_id = item.scan_id;
                end
            end
            OP_POINT:
            begin
                if (in_frame)
                begin
                    stride = (stride_cfg == 8'd0) ? 1 : int'(stride_cfg);
                    take = (stride_pos == 0);
                    stride_pos = (stride_pos + 1 >= stride) ? 0 : stride_pos + 1;
                    if (take && item.data_ok && !rel_overflow)
                    begin
                        ox = round15(rel_cos * px - rel_sin * py + rel_x * 32768);
                        oy = round15(rel_sin * px + rel_cos * py + rel_y * 32768);
                        if (fits32(ox) && fits32(oy))
                        begin
                            kept_pts = bump(kept_pts);
                            emits = 1;
                            res.result_kind = KIND_POINT;
                            res.out_x = ox[31:0];
                            res.out_y = oy[31:0];
                        end
                    end
                end
            end
            default:
            begin
                if (!ctr_present)
                    code = VERDICT_NO_CENTER;
                else if (kept_frames < min_scans_cfg)
                    code = VERDICT_FEW_SCANS;
                else if (kept_pts < min_points_cfg)
                    code = VERDICT_FEW_POINTS;
                else
                    code = VERDICT_AVAILABLE;
                emits = 1;
                res.result_kind = KIND_VERDICT;
                res.verdict_code = code;
                res.available = (code == VERDICT_AVAILABLE);
                res.kept_points = kept_pts;
                res.kept_scans = kept_frames;
                kept_pts = '0;
                kept_frames = '0;
                in_frame = 0;
                stride_pos = 0;
                ctr_present = 0;
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (transfers_due.size() == 0)
        begin
            report_mismatch("unexpected result, kind", 32'(got.result_kind), '0);
            return;
        end
        want = transfers_due.pop_front();
        if (got.result_kind !== want.result_kind)
            report_mismatch("result_kind", 32'(got.result_kind), 32'(want.result_kind));
        if (got.out_x !== want.out_x)
            report_mismatch("out_x", got.out_x, want.out_x);
        if (got.out_y !== want.out_y)
            report_mismatch("out_y", got.out_y, want.out_y);
        if (got.out_scan_id !== want.out_scan_id)
            report_mismatch("out_scan_id", got.out_scan_id, want.out_scan_id);
        if (got.verdict_code !== want.verdict_code)
            report_mismatch("verdict_code", 32'(got.verdict_code), 32'(want.verdict_code));
        if (got.available !== want.available)
            report_mismatch("available", 32'(got.available), 32'(want.available));
        if (got.kept_points !== want.kept_points)
            report_mismatch("kept_points", 32'(got.kept_points), 32'(want.kept_points));
        if (got.kept_scans !== want.kept_scans)
            report_mismatch("kept_scans", 32'(got.kept_scans), 32'(want.kept_scans));
        case (want.result_kind)
            KIND_POINT: points_seen++;
            KIND_FRAME: frames_seen++;
            default:
            begin
                verdicts_seen++;
                if (want.available)
                    available_seen++;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restore_defaults();
            transfers_due.delete();
            mismatches = 0;
            results_due = 0;
            points_seen = 0;
            frames_seen = 0;
            verdicts_seen = 0;
            available_seen = 0;
        end
        else
        begin
            // output first: a result never pairs with an item taken at the same edge
            if (out_valid && out_ready)
                check_result(out_data);
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
            begin
                advance_submap(in_data, step_emits, step_result);
                if (step_emits)
                    transfers_due = {transfers_due, step_result};
            end
            results_due = transfers_due.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import spt_pkg::*;

    // run limit, far above the slowest legal run with both sides idling
    localparam int CYCLE_LIMIT = 1000000;
    // result register latency plus margin for items that leave no result
    localparam int SETTLE_CYCLES = 6;
    // an index that maps to no register
    localparam logic [CFG_INDEX_W-1:0] CFG_NONE = 4'd13;
    localparam logic [31:0] ONE_M = 32'h0001_0000;

    typedef enum int { IDLE_RANDOM, IDLE_NONE, IDLE_LIGHT } idle_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_item_t              out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;

    int mismatches, results_due;
    int points_seen, frames_seen, verdicts_seen, available_seen;

    idle_mode_t  idle_mode = IDLE_RANDOM;
    int          cycle_count;
    int          settings_used = 0;
    int          phase_items;
    logic [31:0] cur_dt;

    submap_point_transform u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // watches all three channels, predicts every result and compares
    spt_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .results_due    (results_due),
        .points_seen    (points_seen),
        .frames_seen    (frames_seen),
        .verdicts_seen  (verdicts_seen),
        .available_seen (available_seen)
    );

    // 125 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog: a hang anywhere ends the run as a failure
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("submap_point_transform test failed");
        $finish;
    end

    // cycles a side waits before its next transfer
    function automatic int idle_gap();
        case (idle_mode)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
            default:    return $urandom_range(0, 12);
        endcase
    endfunction

    // receiver: random stalls between result transfers
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = idle_gap();
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic in_item_t make_item(logic [1:0] op, logic [31:0] id, logic [31:0] stamp,
                                           logic [31:0] x, logic [31:0] y, logic [15:0] yaw,
                                           logic ok);
        in_item_t it;
        it.opcode = op;
        it.scan_id = id;
        it.stamp_us = stamp;
        it.pos_x = x;
        it.pos_y = y;
        it.yaw = yaw;
        it.data_ok = ok;
        return it;
    endfunction

    function automatic in_item_t random_item();
        return make_item(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(),
                         $urandom(), 16'($urandom_range(0, 65535)),
                         1'($urandom_range(0, 1)));
    endfunction

    // mostly within +-256 m, now and then anything at all
    function automatic logic [31:0] coord_offset();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endfunction

    // one input transfer; valid stays up back to back when the gap is zero
    task automatic push_item(input in_item_t item);
        int gap;
        gap = idle_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (!in_ready);
        phase_items++;
    endtask

    // hold the sender until every expected result is out and the pipe is empty
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [7:0] stride, input logic [15:0] scans,
                                  input logic [15:0] pts, input logic [31:0] dt);
        settle();
        cfg_write(CFG_POINT_STRIDE, {24'd0, stride});
        cfg_write(CFG_MIN_SCANS, {16'd0, scans});
        cfg_write(CFG_MIN_POINTS, {16'd0, pts});
        cfg_write(CFG_MAX_DT, dt);
        cur_dt = dt;
        settings_used++;
    endtask

    // hand-picked corners: missing center, window edges, overflows, each verdict
    task automatic directed_items();
        // no center yet: verdict reports it missing
        push_item(make_item(OP_END, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0));
        // header and point with no center go nowhere
        push_item(make_item(OP_HEADER, 32'h1234_5678, 32'd0, ONE_M, ONE_M, 16'd0, 1'b1));
        push_item(make_item(OP_POINT, 32'h0, 32'h0, ONE_M, ONE_M, 16'd0, 1'b1));
        // invalid center leaves no center behind
        push_item(make_item(OP_CENTER, 32'hffff_ffff, 32'd1000, 32'h0, 32'h0, 16'h0, 1'b0));
        push_item(make_item(OP_HEADER, 32'd7, 32'd1000, 32'h0, 32'h0, 16'h0, 1'b1));
        // center at the origin, heading zero
        push_item(make_item(OP_CENTER, 32'd1, 32'd1000, 32'h0, 32'h0, 16'h0, 1'b1));
        // header right on the window edge, turned a quarter
        push_item(make_item(OP_HEADER, 32'd2, 32'd501000, ONE_M, 32'h0002_0000,
                            16'h4000, 1'b1));
        push_item(make_item(OP_POINT, 32'h0, 32'h0, ONE_M, 32'h0, 16'h0, 1'b1));
        // invalid point takes its stride slot but is dropped
        push_item(make_item(OP_POINT, 32'h0, 32'h0, ONE_M, ONE_M, 16'h0, 1'b0));
        // rotated point that leaves the 32-bit range
        push_item(make_item(OP_POINT, 32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000,
                            16'h0, 1'b1));
        // one microsecond past the window: rejected and its points ignored
        push_item(make_item(OP_HEADER, 32'd3, 32'd501001, 32'h0, 32'h0, 16'h0, 1'b1));
        push_item(make_item(OP_POINT, 32'h0, 32'h0, ONE_M, ONE_M, 16'h0, 1'b1));
        // invalid header inside the window
        push_item(make_item(OP_HEADER, 32'd4, 32'd0, 32'h0, 32'h0, 16'h0, 1'b0));
        // one scan and one point: too few points
        push_item(make_item(OP_END, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 1'b1));
        // pose extremes: the frame counts but its translation overflows
        push_item(make_item(OP_CENTER, 32'h8000_0000, 32'hffff_ffff, 32'h8000_0000,
                            32'h7fff_ffff, 16'hffff, 1'b1));
        push_item(make_item(OP_HEADER, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff,
                            32'h8000_0000, 16'h0, 1'b1));
        push_item(make_item(OP_POINT, 32'h0, 32'h0, ONE_M, ONE_M, 16'h0, 1'b1));
        // stamp at the far end of the range from the center
        push_item(make_item(OP_HEADER, 32'd5, 32'd0, 32'h0, 32'h0, 16'h0, 1'b1));
        push_item(make_item(OP_END, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 1'b1));
        // center but no frames: too few scans
        push_item(make_item(OP_CENTER, 32'd9, 32'd5, ONE_M, ONE_M, 16'h8000, 1'b1));
        push_item(make_item(OP_END, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 1'b1));
    endtask

    // one submap: center, a few frames of points, end; sometimes plain noise
    task automatic run_submap();
        logic [31:0] c_stamp, c_x, c_y, stamp, off;
        int          pick, pts;
        pick = $urandom_range(0, 9);
        idle_mode = (pick < 6) ? IDLE_RANDOM : (pick < 8) ? IDLE_LIGHT : IDLE_NONE;
        if ($urandom_range(0, 6) == 0)
        begin
            repeat ($urandom_range(1, 8)) push_item(random_item());
            return;
        end
        c_stamp = $urandom();
        c_x = coord_offset();
        c_y = coord_offset();
        push_item(make_item(OP_CENTER, $urandom(), c_stamp, c_x, c_y,
                            16'($urandom_range(0, 65535)), $urandom_range(0, 9) != 0));
        repeat ($urandom_range(0, 5))
        begin
            // most stamps land inside the window, the rest just outside
            if ($urandom_range(0, 4) != 0)
                off = $urandom_range(0, cur_dt);
            else
                off = cur_dt + 32'd1 + $urandom_range(0, 1000);
            stamp = $urandom_range(0, 1) ? c_stamp + off : c_stamp - off;
            push_item(make_item(OP_HEADER, $urandom(), stamp, c_x + coord_offset(),
                                c_y + coord_offset(), 16'($urandom_range(0, 65535)),
                                $urandom_range(0, 9) != 0));
            pts = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
            repeat (pts)
                push_item(make_item(OP_POINT, $urandom(), $urandom(), coord_offset(),
                                    coord_offset(), 16'($urandom_range(0, 65535)),
                                    $urandom_range(0, 9) != 0));
            if ($urandom_range(0, 9) == 0)
                push_item(random_item());
        end
        // now and then the end is missing and the next center takes over
        if ($urandom_range(0, 9) != 0)
            push_item(make_item(OP_END, $urandom(), $urandom(), $urandom(), $urandom(),
                                16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1))));
    endtask

    // random submaps under one setting, with one full drain half way
    task automatic run_phase(input int budget);
        bit drained;
        drained = 0;
        phase_items = 0;
        while (phase_items < budget)
        begin
            run_submap();
            if (!drained && phase_items >= budget / 2)
            begin
                settle();
                drained = 1;
            end
        end
    endtask

    // main sequence: reset, directed corners, random phases, verdict
    initial
    begin
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_POINT_STRIDE;
        cfg_data = '0;
        rst_n = 1'b0;
        cur_dt = RST_MAX_DT;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_items();

        apply_settings(RST_POINT_STRIDE, RST_MIN_SCANS, RST_MIN_POINTS, RST_MAX_DT);
        run_phase(300);
        apply_settings(8'd2, 16'd2, 16'd5, 32'd1000);
        run_phase(280);
        // a write to no register must leave the setting alone
        settle();
        cfg_write(CFG_NONE, 32'hffff_ffff);
        run_phase(40);
        apply_settings(8'd3, 16'd1, 16'd3, 32'hffff_ffff);
        run_phase(250);
        apply_settings(8'd255, 16'd3, 16'd3, 32'd1);
        run_phase(250);
        // stride zero behaves as one
        apply_settings(8'd0, 16'hffff, 16'hffff, 32'd100000);
        run_phase(180);
        apply_settings(8'($urandom_range(1, 8)), 16'($urandom_range(1, 4)),
                       16'($urandom_range(3, 20)), $urandom_range(1, 2000000));
        run_phase(400);

        settle();
        $display("covered %0d transformed points, %0d frame ids, %0d verdicts (%0d available)",
                 points_seen, frames_seen, verdicts_seen, available_seen);
        $display("across %0d register settings, plus window, stride and overflow corners",
                 settings_used);
        if (mismatches == 0 && results_due == 0)
            $display("submap_point_transform test passed");
        else
            $display("submap_point_transform test failed");
        $finish;
    end

endmodule
